>>> design/drtp_pkg.sv
`default_nettype none

package drtp_pkg;

   // field widths
   localparam int CH_W    = 8;
   localparam int MANT_W  = 60;
   localparam int FRAC_W  = 7;
   localparam int EXPV_W  = 10;
   localparam int EXP_W   = 12;
   localparam int RSP_W   = 80;

   // digit limit of the mantissa and default field length
   localparam int MAX_DIGITS          = 18;
   localparam int MAX_FIELD_CHARS_DEF = 64;

   localparam logic [FRAC_W-1:0] FRAC_MAX = 7'd127;
   localparam logic [13:0]       EXPV_MAX = 14'd999;

   // character codes
   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_E_UP  = 8'h45;
   localparam logic [CH_W-1:0] CH_E_LO  = 8'h65;

   // largest mantissa: 10^MAX_DIGITS - 1, capped at the 60-bit maximum
   function automatic logic [63:0] mant_limit_calc(input int digits);
      logic [63:0] p;
      logic [63:0] cap;
      p   = 64'd1;
      cap = {4'b0, {MANT_W{1'b1}}};
      for (int i = 0; i < digits && i < 19; i++) begin
         p = p * 64'd10;
      end
      p = p - 64'd1;
      return (p > cap) ? cap : p;
   endfunction

   localparam logic [63:0] MANT_LIMIT = mant_limit_calc(MAX_DIGITS);

   // parse state of one field
   typedef struct packed {
      logic [MANT_W-1:0] mant;
      logic [FRAC_W-1:0] frac;
      logic [EXPV_W-1:0] expv;
      logic              in_number;
      logic              infract;
      logic              inexp;
      logic              insn;
      logic              esn;
      logic              expneg;
      logic              neg;
      logic              stopped;
      logic              saturated;
   } parse_state_type;

   localparam parse_state_type PARSE_CLEAR = '0;

   // one result
   typedef struct packed {
      logic                    overflow;
      logic signed [EXP_W-1:0] exponent;
      logic [MANT_W-1:0]       mantissa;
      logic                    negative;
   } result_type;

endpackage

`default_nettype wire

>>> design/decimal_real_text_parser.sv
// Decimal real number parser, one ASCII character per transfer.
//
// Input stream (req_): req_tdata[7:0] is the character, req_tuser marks the
// first character of a field and req_tlast the last one. Leading whitespace,
// one sign, digits with one '.', then 'e'/'E' and a signed exponent are
// parsed; anything else ends the number and the rest of the field is ignored.
// Characters past MAX_FIELD_CHARS in one field are ignored.
//
// Result stream (rsp_): one transfer per field, carrying sign, integer
// mantissa and decimal exponent, value = +/- mantissa * 10^exponent.
//
// The closing character's req_ transfer loads the input register; the result is
// then registered in the result register and offered on rsp_.
// Throughput: one character per cycle but for the stalls below; the step
// per character (mantissa times ten plus digit with saturation compare) is
// combinational, from the input register to the parse state / result registers.
// Stalls: characters that do not close a field keep flowing while a result
// waits; a closing character waits in the input register until rsp_tready.
// Reset clears the parse state and both valid flags.
`default_nettype none

module decimal_real_text_parser #(
   parameter int MAX_FIELD_CHARS = drtp_pkg::MAX_FIELD_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] first
   input  logic        req_tlast,   // last character of the field
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // [0] negative, [60:1] mantissa,
                                    // [72:61] exponent, [73] overflow, rest zero
);
   import drtp_pkg::*;

   localparam int CNT_W = $clog2(MAX_FIELD_CHARS + 1);

   // input register
   logic            in_valid_ff, in_valid_in;
   logic [CH_W-1:0] in_ch_ff;
   logic            in_first_ff;
   logic            in_last_ff;

   // parse state and field character count
   parse_state_type state_ff, state_in, state_nxt;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_base;
   logic            take;

   // result register
   logic            out_valid_ff, out_valid_in;
   result_type      out_ff, result;

   logic            fire;
   logic            in_load;

   // a closing character needs room in the result register
   assign fire       = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign in_load    = req_tvalid && req_tready;

   assign cnt_base = in_first_ff ? '0 : cnt_ff;
   assign take     = cnt_base < CNT_W'(MAX_FIELD_CHARS);

   drtp_step u_step (
      .state_cur (state_ff),
      .ch        (in_ch_ff),
      .first     (in_first_ff),
      .take      (take),
      .state_nxt (state_nxt)
   );

   drtp_emit u_emit (
      .state  (state_nxt),
      .result (result)
   );

   // next values
   always_comb begin
      in_valid_in = in_load ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (fire) begin
         if (in_last_ff) begin
            state_in = PARSE_CLEAR;
            cnt_in   = '0;
         end else begin
            state_in = state_nxt;
            cnt_in   = take ? cnt_base + CNT_W'(1) : cnt_base;
         end
      end

      if (fire && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= PARSE_CLEAR;
         cnt_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_ch_ff    <= req_tdata;
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
      if (fire && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - $bits(result_type)){1'b0}}, out_ff};

endmodule

`default_nettype wire

>>> design/drtp_step.sv
`default_nettype none

module drtp_step (
   input  drtp_pkg::parse_state_type state_cur,
   input  logic [drtp_pkg::CH_W-1:0] ch,
   input  logic                      first,
   input  logic                      take,
   output drtp_pkg::parse_state_type state_nxt
);
   import drtp_pkg::*;

   parse_state_type base;
   logic            digit;
   logic [3:0]      dval;
   logic [63:0]     mant_prod;
   logic [13:0]     expv_prod;
   logic            space;
   logic            is_sign;

   always_comb begin
      base      = first ? PARSE_CLEAR : state_cur;
      digit     = (ch >= CH_ZERO) && (ch <= CH_NINE);
      dval      = digit ? 4'(ch - CH_ZERO) : 4'd0;
      space     = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
      is_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);

      // times ten plus digit, by shift and add
      mant_prod = ({4'b0, base.mant} << 3) + ({4'b0, base.mant} << 1) + {60'b0, dval};
      expv_prod = ({4'b0, base.expv} << 3) + ({4'b0, base.expv} << 1) + {10'b0, dval};

      state_nxt = base;
      if (take && !base.stopped) begin
         if (ch == CH_NUL) begin
            state_nxt.stopped = 1'b1;
         end else if (base.inexp) begin
            // exponent part
            if (digit) begin
               if (expv_prod > EXPV_MAX) begin
                  state_nxt.expv      = EXPV_MAX[EXPV_W-1:0];
                  state_nxt.saturated = 1'b1;
               end else begin
                  state_nxt.expv = expv_prod[EXPV_W-1:0];
               end
               state_nxt.esn = 1'b1;
            end else if (ch == CH_PLUS && !base.esn) begin
               state_nxt.esn = 1'b1;
            end else if (ch == CH_MINUS && !base.esn) begin
               state_nxt.esn    = 1'b1;
               state_nxt.expneg = 1'b1;
            end else begin
               state_nxt.stopped = 1'b1;
            end
         end else if (digit) begin
            // mantissa digit
            if (mant_prod > MANT_LIMIT) begin
               state_nxt.mant      = MANT_LIMIT[MANT_W-1:0];
               state_nxt.saturated = 1'b1;
            end else begin
               state_nxt.mant = mant_prod[MANT_W-1:0];
            end
            if (base.infract) begin
               if (base.frac >= FRAC_MAX) begin
                  state_nxt.saturated = 1'b1;
               end else begin
                  state_nxt.frac = base.frac + 7'd1;
               end
            end
            state_nxt.in_number = 1'b1;
         end else if (is_sign && !(base.in_number || base.insn)) begin
            state_nxt.insn = 1'b1;
            if (ch == CH_MINUS) begin
               state_nxt.neg = 1'b1;
            end
         end else if (ch == CH_DOT && !base.infract) begin
            state_nxt.in_number = 1'b1;
            state_nxt.infract   = 1'b1;
         end else if (ch == CH_E_LO || ch == CH_E_UP) begin
            // bare exponent mark means a mantissa of one
            if (!base.in_number) begin
               state_nxt.mant = {{(MANT_W-1){1'b0}}, 1'b1};
            end
            state_nxt.inexp     = 1'b1;
            state_nxt.in_number = 1'b1;
         end else if (space && !(base.in_number || base.insn)) begin
            state_nxt.stopped = base.stopped;
         end else begin
            state_nxt.stopped = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> design/drtp_emit.sv
`default_nettype none

module drtp_emit (
   input  drtp_pkg::parse_state_type state,
   output drtp_pkg::result_type      result
);
   import drtp_pkg::*;

   logic signed [EXP_W-1:0] exp_mag;
   logic signed [EXP_W-1:0] exp_signed;

   // exponent value with sign, less the fraction digits
   always_comb begin
      exp_mag    = {{(EXP_W-EXPV_W){1'b0}}, state.expv};
      exp_signed = state.expneg ? -exp_mag : exp_mag;
      result.exponent = exp_signed - {{(EXP_W-FRAC_W){1'b0}}, state.frac};
      result.negative = state.neg;
      result.mantissa = state.mant;
      result.overflow = state.saturated;
   end

endmodule

`default_nettype wire

>>> design/drtp_checker.sv
`default_nettype none

module drtp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata
);
   import drtp_pkg::*;

   logic signed [EXP_W-1:0] rsp_exp;
   assign rsp_exp = rsp_tdata[72:61];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // mantissa never passes the digit limit
   a_mant_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {4'b0, rsp_tdata[60:1]} <= MANT_LIMIT)
      else $error("mantissa above limit");

   // exponent stays within saturated range
   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_exp <= 12'sd999) && (rsp_exp >= -12'sd1126))
      else $error("exponent out of range");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind decimal_real_text_parser drtp_checker u_drtp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> tb/sv/decimal_real_text_parser_test.sv
`timescale 1ns / 100ps

module decimal_real_text_parser_test;
   import drtp_pkg::*;

   // limits of the parser as built (default field length)
   localparam logic [63:0] MANT_MAX         = 64'd999_999_999_999_999_999;
   localparam int          EXP_SAT          = 999;
   localparam int          FRAC_SAT         = 127;
   localparam int          FIELD_CHAR_LIMIT = 64;

   // run control
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] ch
   logic        req_tuser;    // [0] first
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;    // [0] negative, [60:1] mantissa, [72:61] exponent, [73] overflow

   // parse state of the predictor
   logic [63:0] p_mant;
   int          p_frac;
   int          p_expv;
   bit          p_inside, p_infract, p_inexp, p_insn, p_esn, p_expneg, p_neg;
   bit          p_stopped, p_sat;
   int          p_count;

   result_type  pending_numbers[$];
   logic [7:0]  field_text[$];

   bit tx_idle_on       = 1'b1;
   bit rx_idle_on       = 1'b1;
   bit rsp_hold_request = 1'b0;

   int errors          = 0;
   int chars_sent      = 0;
   int fields_closed   = 0;
   int results_checked = 0;
   int saturated_seen  = 0;
   int idle_cycles     = 0;

   decimal_real_text_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic void clear_number();
      p_mant    = '0;
      p_frac    = 0;
      p_expv    = 0;
      p_inside  = 0;
      p_infract = 0;
      p_inexp   = 0;
      p_insn    = 0;
      p_esn     = 0;
      p_expneg  = 0;
      p_neg     = 0;
      p_stopped = 0;
      p_sat     = 0;
      p_count   = 0;
   endfunction

   // one accepted character; queues a number when the field closes
   function automatic void parse_char(input logic [7:0] c, input logic first,
                                      input logic last);
      bit         digit;
      bit         blank;
      int         d;
      int         v;
      int         e;
      result_type r;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      d     = digit ? int'(c - CH_ZERO) : 0;

      if (first) clear_number();

      // characters past the field length are dropped
      if (p_count < FIELD_CHAR_LIMIT) begin
         p_count++;
         if (!p_stopped) begin
            if (c == CH_NUL) begin
               p_stopped = 1;
            end else if (p_inexp) begin
               if (digit) begin
                  v = p_expv * 10 + d;
                  if (v > EXP_SAT) begin
                     v     = EXP_SAT;
                     p_sat = 1;
                  end
                  p_expv = v;
                  p_esn  = 1;
               end else if (c == CH_PLUS && !p_esn) begin
                  p_esn = 1;
               end else if (c == CH_MINUS && !p_esn) begin
                  p_esn    = 1;
                  p_expneg = 1;
               end else begin
                  p_stopped = 1;
               end
            end else if (digit) begin
               if (p_mant > (MANT_MAX - 64'(d)) / 64'd10) begin
                  p_mant = MANT_MAX;
                  p_sat  = 1;
               end else begin
                  p_mant = p_mant * 64'd10 + 64'(d);
               end
               if (p_infract) begin
                  if (p_frac >= FRAC_SAT) p_sat = 1;
                  else p_frac++;
               end
               p_inside = 1;
            end else if ((c == CH_PLUS || c == CH_MINUS) && !p_inside && !p_insn) begin
               p_insn = 1;
               if (c == CH_MINUS) p_neg = 1;
            end else if (c == CH_DOT && !p_infract) begin
               p_inside  = 1;
               p_infract = 1;
            end else if (c == CH_E_LO || c == CH_E_UP) begin
               // exponent mark with no digits before it means 1eN
               if (!p_inside) p_mant = 64'd1;
               p_inexp  = 1;
               p_inside = 1;
            end else if (blank && !p_inside && !p_insn) begin
               // leading whitespace, skipped
            end else begin
               p_stopped = 1;
            end
         end
      end

      if (last) begin
         e = p_expneg ? -p_expv : p_expv;
         e = e - p_frac;
         r.negative = p_neg;
         r.mantissa = p_mant[MANT_W-1:0];
         r.exponent = e[EXP_W-1:0];
         r.overflow = p_sat;
         pending_numbers.push_back(r);
         fields_closed++;
         if (p_sat) saturated_seen++;
         clear_number();
      end
   endfunction

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------
   task automatic send_char(input logic [7:0] c, input logic first, input logic last);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= first;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      parse_char(c, first, last);
   endtask

   task automatic send_field(input bit mark_first, input bit mark_last);
      for (int i = 0; i < field_text.size(); i++) begin
         send_char(field_text[i], mark_first && (i == 0),
                   mark_last && (i == field_text.size() - 1));
      end
   endtask

   task automatic send_text(input string s, input bit mark_first = 1,
                            input bit mark_last = 1);
      field_text.delete();
      for (int i = 0; i < s.len(); i++) field_text.push_back(s[i]);
      send_field(mark_first, mark_last);
   endtask

   // stop offering and wait for every outstanding number
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_numbers.size() != 0) @(posedge clock);
   endtask

   task automatic push_digits(input int n);
      repeat (n) field_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   // mostly well-formed number text with random content, sometimes junk after it
   task automatic build_number();
      int k;
      field_text.delete();
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            k = $urandom_range(0, 5);
            field_text.push_back(k == 5 ? CH_SPACE : 8'(CH_TAB + k));
         end
      end
      if ($urandom_range(0, 1)) field_text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      push_digits($urandom_range(0, 9) == 0 ? $urandom_range(15, 24) : $urandom_range(0, 6));
      if ($urandom_range(0, 2) == 0) begin
         field_text.push_back(CH_DOT);
         push_digits($urandom_range(0, 5));
      end
      if ($urandom_range(0, 3) == 0) begin
         field_text.push_back($urandom_range(0, 1) ? CH_E_UP : CH_E_LO);
         if ($urandom_range(0, 1)) field_text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
         push_digits($urandom_range(0, 7) == 0 ? $urandom_range(4, 5) : $urandom_range(0, 3));
      end
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 4)) field_text.push_back(8'($urandom_range(0, 255)));
      end
      if (field_text.size() == 0) push_digits(1);
   endtask

   // ---------------------------------------------------------------
   // receiver side: random stalls, plus one long hold on request
   // ---------------------------------------------------------------
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold_request = 1'b0;
         end
         n = rx_idle_on ? $urandom_range(0, 9) : 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------
   task automatic check_number(input logic [79:0] data);
      result_type got;
      result_type want;
      got = result_type'(data[73:0]);
      if (pending_numbers.size() == 0) begin
         $display("%0t: result with nothing expected: actual %h", $time, data);
         errors++;
      end else begin
         want = pending_numbers.pop_front();
         results_checked++;
         if (got.negative !== want.negative) begin
            $display("%0t: negative mismatch: expected %0d actual %0d",
                     $time, want.negative, got.negative);
            errors++;
         end
         if (got.mantissa !== want.mantissa) begin
            $display("%0t: mantissa mismatch: expected %0d actual %0d",
                     $time, want.mantissa, got.mantissa);
            errors++;
         end
         if (got.exponent !== want.exponent) begin
            $display("%0t: exponent mismatch: expected %0d actual %0d",
                     $time, $signed(want.exponent), $signed(got.exponent));
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch: expected %0d actual %0d",
                     $time, want.overflow, got.overflow);
            errors++;
         end
         if (data[79:74] !== 6'd0) begin
            $display("%0t: padding mismatch: expected 0 actual %h", $time, data[79:74]);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_number(rsp_tdata);
   end

   // watchdog on cycles without any transfer
   initial begin
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d numbers outstanding",
                     $time, STALL_LIMIT, pending_numbers.size());
            $display("decimal_real_text_parser regression: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   task automatic test_plain_numbers();
      send_text("0");
      send_text("9");
      send_text("  +12.5");
      send_text("-0");                // negative zero
      send_text("\t-3.25e+4");
      send_text(".5");
      send_text("5.");
      send_text("e5");                // exponent mark without digits
      send_text("-E-3");
      wait_drained();
   endtask

   task automatic test_stop_conditions();
      send_text("12x34");
      send_text("1.2.3");
      send_text("--5");
      send_text("1+2");
      send_text("1e++3");
      send_text("1e5e6");
      send_text(" 1 2");
      // NUL ends the number
      field_text = '{8'h31, 8'h32, CH_NUL, 8'h33, 8'h34};
      send_field(1, 1);
      field_text = '{8'hFF, 8'h31};
      send_field(1, 1);
      wait_drained();
   endtask

   task automatic test_saturation();
      send_text("999999999999999999");
      send_text("1234567890123456789012");
      send_text("1e9999");
      send_text("-1.5e-1000");
      wait_drained();
   endtask

   // first/last flag handling: missing first, restart, split field
   task automatic test_field_flags();
      send_text("42", 0, 1);
      send_text("99", 1, 0);
      send_text("7", 1, 1);
      send_text("1", 1, 0);
      send_text("5", 0, 0);
      send_text("e2", 0, 1);
      wait_drained();
   endtask

   // fields longer than the character limit, and a long one within it
   task automatic test_long_fields();
      field_text.delete();
      push_digits(75);
      send_field(1, 1);
      field_text = '{8'h30, CH_DOT};
      push_digits(70);
      send_field(1, 1);
      field_text.delete();
      repeat (FIELD_CHAR_LIMIT) field_text.push_back(CH_SPACE);
      field_text.push_back(8'h37);
      send_field(1, 1);
      field_text.delete();
      repeat (FIELD_CHAR_LIMIT - 1) field_text.push_back(CH_SPACE);
      field_text.push_back(8'h37);
      field_text.push_back(8'h38);
      send_field(1, 1);
      field_text = '{CH_MINUS};
      push_digits(40);
      field_text.push_back(CH_DOT);
      push_digits(3);
      field_text.push_back(CH_E_LO);
      field_text.push_back(CH_MINUS);
      push_digits(5);
      send_field(1, 1);
      wait_drained();
   endtask

   task automatic test_random_fields();
      int stop_at;
      int kind;
      stop_at = chars_sent + 300;
      while (chars_sent < stop_at) begin
         if ($urandom_range(0, 15) == 0) tx_idle_on = !tx_idle_on;
         if ($urandom_range(0, 15) == 0) rx_idle_on = !rx_idle_on;
         kind = $urandom_range(0, 19);
         if (kind < 3) begin
            // noise over the whole byte range
            field_text.delete();
            repeat ($urandom_range(1, 8)) field_text.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_number();
         end
         // broken field: opened, never closed, then restarted
         if (kind == 3) begin
            send_field(1, 0);
            build_number();
         end
         send_field(kind != 4, 1);
      end
      tx_idle_on = 1;
      rx_idle_on = 1;
      wait_drained();
   endtask

   // receiver holds off while the sender keeps going at full rate
   task automatic test_backpressure();
      rsp_hold_request = 1'b1;
      tx_idle_on       = 0;
      repeat (20) begin
         build_number();
         send_field(1, 1);
      end
      tx_idle_on = 1;
      wait_drained();
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      clear_number();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_plain_numbers();
      test_stop_conditions();
      test_saturation();
      test_field_flags();
      test_long_fields();
      test_backpressure();
      test_random_fields();

      wait_drained();
      repeat (8) @(posedge clock);
      if (pending_numbers.size() != 0) begin
         $display("%0t: %0d numbers never arrived", $time, pending_numbers.size());
         errors++;
      end

      $display("Covered %0d characters in %0d closed fields; %0d numbers checked, %0d saturated.",
               chars_sent, fields_closed, results_checked, saturated_seen);
      $display("Mismatches found: %0d", errors);
      if (errors == 0) begin
         $display("decimal_real_text_parser regression: pass");
      end else begin
         $display("decimal_real_text_parser regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
design/drtp_pkg.sv
design/drtp_step.sv
design/drtp_emit.sv
design/decimal_real_text_parser.sv
design/drtp_checker.sv
tb/sv/decimal_real_text_parser_test.sv
